### hdl/uniform_dequantizer_unpacker_macros.svh
// Assertion macros shared by the dequantizer unpacker modules.
`ifndef UNIFORM_DEQUANTIZER_UNPACKER_MACROS_SVH
`define UNIFORM_DEQUANTIZER_UNPACKER_MACROS_SVH

`ifndef SYNTHESIS
`define UDQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UDQ_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define UDQ_ASSERT(lbl, clk, rst, prop, msg)
`define UDQ_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

### hdl/udq_pkg.sv
// Shared types, constants and helper functions of the dequantizer unpacker.
`timescale 1ns / 1ps
package udq_pkg;

  localparam int BYTE_W      = 8;
  localparam int WIDTH_W     = 4;
  localparam int PAD_W       = 3;
  localparam int ACC_W       = 15;
  localparam int STORE_W     = 7;
  localparam int CNT_W       = 4;
  localparam int MAX_CODES   = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BITS   = 1'd1;

  localparam logic [WIDTH_W-1:0] CODE_WIDTH_RESET = 4'd1;
  localparam logic [PAD_W-1:0]   PAD_BITS_RESET   = 3'd0;

  // One accepted byte that yields at least one pixel.
  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic [CNT_W-1:0]   avail;
    logic [CNT_W-1:0]   num;
    logic [WIDTH_W-1:0] width;
    logic               fin;
  } udq_entry_t;

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] cw);
    logic [WIDTH_W-1:0] w;
    if (cw == 4'd0) begin
      w = 4'd1;
    end else if (cw > 4'd8) begin
      w = 4'd8;
    end else begin
      w = cw;
    end
    return w;
  endfunction

  function automatic logic [BYTE_W-1:0] dequant(input logic [BYTE_W-1:0] code,
                                                input logic [WIDTH_W-1:0] w);
    logic [BYTE_W-1:0] px;
    if (w >= 4'd8) begin
      px = '0;
    end else begin
      px = code << (4'd8 - w);
    end
    return px;
  endfunction

endpackage

### hdl/udq_front.sv
// Front part: joins kept bits with each byte, counts whole codes, updates the kept bits.
`timescale 1ns / 1ps
module udq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [udq_pkg::WIDTH_W-1:0]   code_width,
  input  logic [udq_pkg::PAD_W-1:0]     pad_bits,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [udq_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          final_byte,
  input  logic                          q_full,
  output logic                          q_push,
  output udq_pkg::udq_entry_t           q_entry
);
  import udq_pkg::*;

  logic [STORE_W-1:0] bit_store;
  logic [STORE_W-1:0] bit_store_next;
  logic [2:0]         bit_count;
  logic [2:0]         bit_count_next;

  logic [WIDTH_W-1:0] w;
  logic [ACC_W-1:0]   acc;
  logic [CNT_W-1:0]   avail;
  logic [CNT_W-1:0]   num;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   rem;
  logic [7:0]         rem_mask;
  logic               accept;

  always_comb begin
    w     = eff_width(code_width);
    acc   = {bit_store, data_byte};
    avail = {1'b0, bit_count} + 4'd8;
    if (final_byte) begin
      acc   = acc >> pad_bits;
      avail = avail - {1'b0, pad_bits};
    end
    num = '0;
    for (int k = 1; k <= MAX_CODES; k++) begin
      if ((7'(k) * {3'b000, w}) <= {3'b000, avail}) begin
        num = CNT_W'(k);
      end
    end
    used     = num * w;
    rem      = avail - used;
    rem_mask = (8'd1 << rem) - 8'd1;
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (num != '0);

  always_comb begin
    q_entry.acc   = acc;
    q_entry.avail = avail;
    q_entry.num   = num;
    q_entry.width = w;
    q_entry.fin   = final_byte;
    if (final_byte) begin
      bit_store_next = '0;
      bit_count_next = '0;
    end else begin
      bit_store_next = acc[STORE_W-1:0] & rem_mask[STORE_W-1:0];
      bit_count_next = rem[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store <= '0;
      bit_count <= '0;
    end else if (accept) begin
      bit_store <= bit_store_next;
      bit_count <= bit_count_next;
    end
  end

endmodule

### hdl/udq_fifo.sv
// Short queue of classified bytes between the front and back parts.
`timescale 1ns / 1ps
`include "uniform_dequantizer_unpacker_macros.svh"
module udq_fifo #(
  parameter int Depth = udq_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  udq_pkg::udq_entry_t  push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output udq_pkg::udq_entry_t  head
);
  import udq_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  udq_entry_t          slots [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     fill;

  assign full       = (fill == CntW'(Depth));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `UDQ_NEVER(a_no_overflow, clk, rst, push && full, "push into a full queue")
  `UDQ_NEVER(a_no_underflow, clk, rst, pop && !head_valid, "pop from an empty queue")

endmodule

### hdl/udq_back.sv
// Back part: one code per cycle from queue head to output reg when free or being read.
`timescale 1ns / 1ps
`include "uniform_dequantizer_unpacker_macros.svh"
module udq_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  udq_pkg::udq_entry_t         head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [udq_pkg::BYTE_W-1:0]  pixel,
  output logic                        last_in_run,
  output logic                        end_of_stream
);
  import udq_pkg::*;

  logic [2:0]         idx;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   pos_cur;
  logic [CNT_W-1:0]   pos_new;
  logic [8:0]         code_mask;
  logic [BYTE_W-1:0]  code;
  logic               slot_free;
  logic               fire;
  logic               last_code;

  always_comb begin
    pos_cur   = (idx == 3'd0) ? head.avail : pos;
    pos_new   = pos_cur - head.width;
    code_mask = (9'd1 << head.width) - 9'd1;
    code      = BYTE_W'(head.acc >> pos_new) & code_mask[BYTE_W-1:0];
    slot_free = !out_valid || out_ready;
    fire      = head_valid && slot_free;
    last_code = (({1'b0, idx} + 4'd1) == head.num);
  end

  assign pop = fire && last_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (fire) begin
      out_valid <= 1'b1;
      idx       <= last_code ? 3'd0 : idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pos           <= pos_new;
      pixel         <= dequant(code, head.width);
      last_in_run   <= last_code;
      end_of_stream <= last_code && head.fin;
    end
  end

  `UDQ_ASSERT(a_head_has_codes, clk, rst,
    head_valid |-> (head.num != 4'd0 && head.num <= 4'd8), "queue head with no codes")
  `UDQ_ASSERT(a_eos_is_last, clk, rst,
    out_valid && end_of_stream |-> last_in_run, "end of stream on a pixel not last in run")
  `UDQ_ASSERT(a_idx_steps, clk, rst,
    fire && !last_code |=> idx == $past(idx) + 3'd1, "code index did not advance")

endmodule

### hdl/uniform_dequantizer_unpacker.sv
// Top level of the uniform dequantizer unpacker: configuration registers and the parts.
// A byte's first pixel is written into the queue at the byte's transfer and is then taken
// from the queue head into the output register once that register is free or being read.
// Throughput: one pixel per cycle from the back part while the output register is free
// or being read; a byte yields N pixels, where N (0 to 8) is the number of whole codes it completes.
// Reset clears the kept bits, the queue and out_valid, and sets code_width
// to 1 and pad_bits to 0.
`timescale 1ns / 1ps
module uniform_dequantizer_unpacker #(
  parameter int QueueDepth = udq_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [udq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [udq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [udq_pkg::BYTE_W-1:0]       data_byte,
  input  logic                             final_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [udq_pkg::BYTE_W-1:0]       pixel,
  output logic                             last_in_run,
  output logic                             end_of_stream
);
  import udq_pkg::*;

  logic [WIDTH_W-1:0] code_width;
  logic [PAD_W-1:0]   pad_bits;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_head_valid;
  udq_entry_t q_entry;
  udq_entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_width <= CODE_WIDTH_RESET;
      pad_bits   <= PAD_BITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CODE_WIDTH: code_width <= cfg_data[WIDTH_W-1:0];
        REG_PAD_BITS:   pad_bits   <= cfg_data[PAD_W-1:0];
        default:        ;
      endcase
    end
  end

  udq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .code_width (code_width),
    .pad_bits   (pad_bits),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  udq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  udq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel         (pixel),
    .last_in_run   (last_in_run),
    .end_of_stream (end_of_stream)
  );

endmodule

### sim/testbench.sv
// Self-checking testbench for the uniform dequantizer unpacker with a built-in predictor.
`timescale 1ns / 1ps
module testbench;
  import udq_pkg::*;

  localparam int RANDOM_BYTES = 350;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT = 3000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [7:0] px;
    logic       last_run;
    logic       eos;
  } pixel_t;

  typedef struct packed {
    logic [3:0] cw;
    logic [2:0] pad;
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic [3:0] n;
    logic [7:0] px;
  } row_t;

  // Rows with typed set carry their own expectation: n pixels that all equal px.
  localparam row_t DIRECTED_ROWS [0:23] = '{
    '{4'd1,  3'd0, 8'hFF, 1'b0, 1'b1, 4'd8, 8'h80},
    '{4'd1,  3'd0, 8'h00, 1'b0, 1'b1, 4'd8, 8'h00},
    '{4'd1,  3'd7, 8'hFF, 1'b1, 1'b1, 4'd1, 8'h80},
    '{4'd8,  3'd0, 8'hAB, 1'b0, 1'b1, 4'd1, 8'h00},
    '{4'd8,  3'd0, 8'hFF, 1'b1, 1'b1, 4'd1, 8'h00},
    '{4'd15, 3'd0, 8'h5A, 1'b0, 1'b1, 4'd1, 8'h00},
    '{4'd0,  3'd0, 8'hFF, 1'b0, 1'b1, 4'd8, 8'h80},
    '{4'd3,  3'd0, 8'hB6, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd3,  3'd0, 8'h6D, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd5,  3'd0, 8'hC3, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd5,  3'd3, 8'h9E, 1'b1, 1'b0, 4'd0, 8'h00},
    '{4'd7,  3'd0, 8'h01, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd7,  3'd0, 8'hFE, 1'b1, 1'b0, 4'd0, 8'h00},
    '{4'd4,  3'd5, 8'hF0, 1'b1, 1'b1, 4'd0, 8'h00},
    '{4'd6,  3'd0, 8'h3F, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd6,  3'd4, 8'hFF, 1'b1, 1'b0, 4'd0, 8'h00},
    '{4'd6,  3'd7, 8'h80, 1'b1, 1'b1, 4'd0, 8'h00},
    '{4'd2,  3'd0, 8'hE4, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd7,  3'd0, 8'h55, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd7,  3'd0, 8'hAA, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd7,  3'd0, 8'h33, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd1,  3'd0, 8'h0F, 1'b0, 1'b0, 4'd0, 8'h00},
    '{4'd2,  3'd6, 8'hFF, 1'b1, 1'b0, 4'd0, 8'h00},
    '{4'd7,  3'd0, 8'h7F, 1'b1, 1'b0, 4'd0, 8'h00}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic final_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BYTE_W-1:0] pixel;
  logic last_in_run;
  logic end_of_stream;

  logic [3:0] width_reg = CODE_WIDTH_RESET;
  logic [2:0] pad_reg = PAD_BITS_RESET;
  logic [14:0] kept_bits = '0;
  logic [3:0] kept_count = '0;

  pixel_t pending_pixels [$];
  pixel_t run_pixels [$];
  int mismatch_count = 0;
  int burst_left = 0;
  int stall_cycles = 0;
  logic [7:0] rx_tick = '0;
  logic [1:0] rx_mode = '0;

  uniform_dequantizer_unpacker i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .final_byte    (final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel         (pixel),
    .last_in_run   (last_in_run),
    .end_of_stream (end_of_stream)
  );

  always #5 clk = ~clk;

  function automatic int unpack_byte(input logic [7:0] b, input logic fin);
    logic [3:0] w;
    logic [31:0] acc;
    logic [31:0] avail;
    logic [31:0] code;
    int n;
    pixel_t p;
    if (width_reg == 4'd0) begin
      w = 4'd1;
    end else if (width_reg > 4'd8) begin
      w = 4'd8;
    end else begin
      w = width_reg;
    end
    acc = {17'd0, kept_bits[6:0], b};
    avail = 32'(kept_count[2:0]) + 32'd8;
    acc = acc & ((32'd1 << avail) - 32'd1);
    if (fin) begin
      acc = acc >> pad_reg;
      avail = avail - 32'(pad_reg);
    end
    n = 0;
    run_pixels.delete();
    while (avail >= 32'(w) && n < 8) begin
      avail = avail - 32'(w);
      code = (acc >> avail) & ((32'd1 << w) - 32'd1);
      p.px = (w >= 4'd8) ? 8'd0 : 8'(code << (4'd8 - w));
      p.last_run = 1'b0;
      p.eos = 1'b0;
      run_pixels.push_back(p);
      n++;
    end
    if (n > 0) begin
      run_pixels[n-1].last_run = 1'b1;
      run_pixels[n-1].eos = fin;
    end
    if (fin) begin
      kept_bits = '0;
      kept_count = '0;
    end else begin
      kept_bits = 15'(acc & ((32'd1 << avail) - 32'd1));
      kept_count = avail[3:0];
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input int expected, input int got);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, expected, got);
    end
    mismatch_count++;
  endtask

  // Leaves valid high after the transfer; the next call or drain_pixels takes it over.
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [3:0] n, input logic [7:0] px);
    int gap;
    int count;
    pixel_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    data_byte <= b;
    final_byte <= fin;
    do begin
      @(negedge clk);
    end while (!in_ready);
    count = unpack_byte(b, fin);
    if (typed) begin
      for (int k = 0; k < n; k++) begin
        p.px = px;
        p.last_run = (k == n - 1);
        p.eos = fin && (k == n - 1);
        pending_pixels.push_back(p);
      end
    end else begin
      for (int k = 0; k < count; k++) begin
        pending_pixels.push_back(run_pixels[k]);
      end
    end
    @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] cw, input logic [2:0] pad);
    cfg_we <= 1'b1;
    cfg_index <= REG_CODE_WIDTH;
    cfg_data <= cw;
    @(posedge clk);
    cfg_index <= REG_PAD_BITS;
    cfg_data <= {1'($urandom_range(0, 1)), pad};
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = cw;
    pad_reg = pad;
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[4:0] == 5'd31) begin
      rx_mode <= 2'($urandom_range(0, 3));
    end
    case (rx_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rx_tick[1:0] == 2'd0);
      default: out_ready <= (rx_tick[4:3] == 2'd3);
    endcase
  end

  always @(negedge clk) begin
    pixel_t exp_px;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel transfer with nothing expected", -1, pixel);
      end else begin
        exp_px = pending_pixels.pop_front();
        if (pixel !== exp_px.px) begin
          report_mismatch("pixel", exp_px.px, pixel);
        end
        if (last_in_run !== exp_px.last_run) begin
          report_mismatch("last_in_run", exp_px.last_run, last_in_run);
        end
        if (end_of_stream !== exp_px.eos) begin
          report_mismatch("end_of_stream", exp_px.eos, end_of_stream);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int sent;
    int len;
    bit noisy;
    logic [3:0] cw;
    logic fin;
    row_t row;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      if (row.cw != width_reg || row.pad != pad_reg) begin
        drain_pixels();
        set_config(row.cw, row.pad);
      end
      send_byte(row.data, row.fin, row.typed, row.n, row.px);
    end
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) < 7) begin
        drain_pixels();
        if ($urandom_range(0, 9) == 0) begin
          cw = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
        end else begin
          cw = 4'($urandom_range(1, 8));
        end
        set_config(cw, 3'($urandom_range(0, 7)));
      end
      len = $urandom_range(1, 12);
      noisy = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len && sent < RANDOM_BYTES; k++) begin
        if (noisy) begin
          fin = 1'($urandom_range(0, 1));
        end else begin
          fin = (k == len - 1) && ($urandom_range(0, 19) != 0);
        end
        send_byte(8'($urandom_range(0, 255)), fin, 1'b0, 4'd0, 8'd0);
        sent++;
      end
    end
    drain_pixels();
    if (pending_pixels.size() != 0) begin
      report_mismatch("pixels never produced", pending_pixels.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/udq_pkg.sv
hdl/udq_front.sv
hdl/udq_fifo.sv
hdl/udq_back.sv
hdl/uniform_dequantizer_unpacker.sv
sim/testbench.sv
